>>> design/rspb_pkg.sv
// Shared types, constants and helpers of the radial shell profile binner.
package rspb_pkg;

    localparam int NUM_BINS  = 64;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NB_W      = 7;
    localparam int DIV_W     = 48;
    localparam int QUOT_W    = 32;
    localparam int STEP_W    = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_OUTER_RADIUS,
        CFG_BINS_IN_USE,
        CFG_INV_BIN_WIDTH,
        CFG_PARTICLE_MASS,
        CFG_INV_SHELL_VOL
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_SQ_MUL,
        S_SQ_ADD,
        S_SQRT,
        S_IDX_MUL,
        S_IDX,
        S_UDIV_GO,
        S_UDIV_WAIT,
        S_DOT_MUL,
        S_DOT_ADD,
        S_W_MUL,
        S_UPD,
        S_RD_ADDR,
        S_MV_CHK,
        S_MV_WAIT,
        S_DN_MUL1,
        S_DN_MUL2,
        S_DN_CHK,
        S_DN_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   divisor;
        logic [DIV_W-1:0]   rem;
        logic [QUOT_W-1:0]  bits;
        logic [STEP_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic signed [63:0] vel_sum;
        logic [47:0]        mass_sum;
        logic [31:0]        count;
    } t_entry;

    // Shell volume ratio 3i^2 + 3i + 1 for shell i
    function automatic logic [13:0] shell_div(input logic [BIN_W-1:0] idx);
        int ii;
        ii = int'(idx);
        return 14'(3 * ii * ii + 3 * ii + 1);
    endfunction

endpackage

>>> design/rspb_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the binner.
module rspb_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rspb_pkg::t_div_req i_req,
    output rspb_pkg::t_div_rsp o_rsp
);
    import rspb_pkg::*;

    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_div;
    logic [QUOT_W-1:0] r_bits;
    logic [QUOT_W-1:0] r_quot;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W:0]    shifted;
    logic              ge;

    always_comb begin
        shifted = {r_rem, r_bits[QUOT_W-1]};
        ge      = shifted >= {1'b0, r_div};
        n_rem   = ge ? DIV_W'(shifted - {1'b0, r_div}) : shifted[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_div  <= i_req.divisor;
            r_bits <= i_req.bits;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_bits <= {r_bits[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while still iterating");

endmodule

>>> design/radial_shell_profile_binner_core.sv
// Radial shell profile binner: sequencer, shared multiplier, shell store and sqrt.
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_ready  | op, pos_x/y/z, vel_x/y/z, read_bin
//  out     | output    | o_out_valid / i_out_ready| bin_number, mean, density, mass, count
//  cfg     | input     | i_cfg_wr_en              | i_cfg_index, i_cfg_wr_data
//
// An accumulate item uses 32 square-root steps, three 17-step
// unit-vector divisions and one registered 32x32 multiplier used for every product.
// A read item uses two 32-step divisions on the divider.
// Reset clears the shell valid flags at once; no clearing pass is needed.
// A finished read result waits in the output register; a new item is taken meanwhile.
module radial_shell_profile_binner_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rspb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic signed [31:0]            i_pos_x,
    input  logic signed [31:0]            i_pos_y,
    input  logic signed [31:0]            i_pos_z,
    input  logic signed [31:0]            i_vel_x,
    input  logic signed [31:0]            i_vel_y,
    input  logic signed [31:0]            i_vel_z,
    input  logic [5:0]                    i_read_bin,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [5:0]                    o_bin_number,
    output logic signed [31:0]            o_mean_radial_velocity,
    output logic [31:0]                   o_shell_density,
    output logic [47:0]                   o_shell_mass,
    output logic [31:0]                   o_shell_count
);
    import rspb_pkg::*;

    // configuration
    logic signed [31:0] r_center [3];
    logic [31:0]        r_outer;
    logic [NB_W-1:0]    r_bins;
    logic [31:0]        r_ibw;
    logic [31:0]        r_mass;
    logic [31:0]        r_iusv;

    t_state r_state, n_state;

    // item
    logic [32:0]      r_dmag [3];
    logic             r_dneg [3];
    logic [31:0]      r_vmag [3];
    logic             r_vneg [3];
    logic [BIN_W-1:0] r_bin;
    logic [1:0]       r_axis;

    // arithmetic
    logic [63:0]        r_prod;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        r_sq;
    logic [63:0]        r_x, r_res, r_bit;
    logic [4:0]         r_cnt;
    logic [31:0]        r_r;
    logic [BIN_W-1:0]   r_ind;
    logic signed [49:0] r_dot;
    logic               r_vr_neg;
    logic [31:0]        r_mean;
    logic [54:0]        r_xh;
    logic               r_xh_ovf;
    logic [31:0]        r_dens;

    // shell store
    t_entry             r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_valid;
    t_entry             r_mem_q;
    logic               r_mem_hit;
    t_entry             ent;
    logic               mem_re;
    logic [BIN_W-1:0]   mem_raddr;
    logic               mem_we;
    t_entry             n_entry;

    // output register
    logic             r_out_valid;
    logic [5:0]       r_o_bin;
    logic [31:0]      r_o_mean;
    logic [31:0]      r_o_dens;
    logic [47:0]      r_o_mass;
    logic [31:0]      r_o_count;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic        in_fire;
    logic [32:0] dsub [3];
    logic [32:0] dabs [3];
    logic [31:0] vin [3];
    logic [31:0] vabs [3];
    logic        far;
    logic [64:0] sq_sum;
    logic [63:0] trial, n_x, n_res;
    logic        sq_ge;
    logic [NB_W-1:0]  nb;
    logic [BIN_W-1:0] ind;
    logic [49:0] dot_abs;
    logic [33:0] dot_m;
    logic [31:0] vr_mag;
    logic [49:0] term;
    logic [63:0] vs_abs;
    logic        mv_zero, mv_sat;
    logic [63:0] dn_sum;
    logic [13:0] dn_k;
    logic        dn_sat;
    logic [47:0] w;
    logic [65:0] vs_new;
    logic [48:0] ms_new;
    logic        out_load;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign ent        = r_mem_hit ? r_mem_q : '0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_outer     <= 32'd65536;
            r_bins      <= NB_W'(NUM_BINS);
            r_ibw       <= 32'd4194304;
            r_mass      <= 32'd65536;
            r_iusv      <= 32'd65536;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X:      r_center[0] <= i_cfg_wr_data;
                CFG_CENTER_Y:      r_center[1] <= i_cfg_wr_data;
                CFG_CENTER_Z:      r_center[2] <= i_cfg_wr_data;
                CFG_OUTER_RADIUS:  r_outer     <= i_cfg_wr_data;
                CFG_BINS_IN_USE:   r_bins      <= i_cfg_wr_data[NB_W-1:0];
                CFG_INV_BIN_WIDTH: r_ibw       <= i_cfg_wr_data;
                CFG_PARTICLE_MASS: r_mass      <= i_cfg_wr_data;
                CFG_INV_SHELL_VOL: r_iusv      <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // shared combinational terms
    always_comb begin
        vin[0] = i_vel_x;
        vin[1] = i_vel_y;
        vin[2] = i_vel_z;
        dsub[0] = {i_pos_x[31], i_pos_x} - {r_center[0][31], r_center[0]};
        dsub[1] = {i_pos_y[31], i_pos_y} - {r_center[1][31], r_center[1]};
        dsub[2] = {i_pos_z[31], i_pos_z} - {r_center[2][31], r_center[2]};
        for (int k = 0; k < 3; k++) begin
            dabs[k] = dsub[k][32] ? 33'(-dsub[k]) : dsub[k];
            vabs[k] = vin[k][31] ? 32'(-vin[k]) : vin[k];
        end

        far    = r_dmag[0][32] | r_dmag[1][32] | r_dmag[2][32];
        sq_sum = {1'b0, r_sq} + {1'b0, r_prod};

        trial = r_res + r_bit;
        sq_ge = r_x >= trial;
        n_x   = sq_ge ? r_x - trial : r_x;
        n_res = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;

        if (r_bins == '0)
            nb = NB_W'(1);
        else if (r_bins > NB_W'(NUM_BINS))
            nb = NB_W'(NUM_BINS);
        else
            nb = r_bins;
        if (r_prod[63:32] >= {{(32-NB_W){1'b0}}, nb})
            ind = BIN_W'(nb - 1'b1);
        else
            ind = r_prod[32+BIN_W-1:32];

        term    = r_prod[49:0];
        dot_abs = r_dot[49] ? 50'(-r_dot) : 50'(r_dot);
        dot_m   = dot_abs[49:FRAC_BITS];
        if (r_dot[49])
            vr_mag = (dot_m > 34'h080000000) ? 32'h80000000 : dot_m[31:0];
        else
            vr_mag = (dot_m > 34'h07FFFFFFF) ? 32'h7FFFFFFF : dot_m[31:0];

        vs_abs  = ent.vel_sum[63] ? 64'(-ent.vel_sum) : 64'(ent.vel_sum);
        mv_zero = (ent.mass_sum == '0);
        mv_sat  = vs_abs >= {ent.mass_sum, 16'b0};

        dn_k   = shell_div(r_bin);
        dn_sum = {1'b0, r_xh, 8'b0} + {16'b0, r_prod[63:16]};
        dn_sat = r_xh_ovf || (dn_sum >= {18'b0, dn_k, 32'b0});

        // shell update from the weighted velocity in the product register
        w      = r_prod[63:16];
        vs_new = {{2{ent.vel_sum[63]}}, ent.vel_sum}
               + (r_vr_neg ? 66'(-{18'b0, w}) : {18'b0, w});
        ms_new = {1'b0, ent.mass_sum} + {17'b0, r_mass};
        if (vs_new[65:63] == 3'b000 || vs_new[65:63] == 3'b111)
            n_entry.vel_sum = vs_new[63:0];
        else
            n_entry.vel_sum = vs_new[65] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        n_entry.mass_sum = ms_new[48] ? '1 : ms_new[47:0];
        n_entry.count    = (&ent.count) ? ent.count : ent.count + 1'b1;
    end

    // sign and saturate a mean magnitude
    function automatic logic [31:0] mean_sat(input logic [31:0] q, input logic neg);
        logic [31:0] m;
        if (neg) begin
            m = (q > 32'h80000000) ? 32'h80000000 : q;
            return 32'(-m);
        end
        return (q > 32'h7FFFFFFF) ? 32'h7FFFFFFF : q;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (in_fire) n_state = i_op ? S_RD_ADDR : S_CHK;
            S_CHK:       n_state = far ? S_IDLE : S_SQ_MUL;
            S_SQ_MUL:    n_state = S_SQ_ADD;
            S_SQ_ADD: begin
                if (sq_sum[64])
                    n_state = S_IDLE;
                else if (r_axis == 2'd2)
                    n_state = S_SQRT;
                else
                    n_state = S_SQ_MUL;
            end
            S_SQRT:      if (r_cnt == 5'd31) n_state = S_IDX_MUL;
            S_IDX_MUL:   n_state = (r_r >= r_outer) ? S_IDLE : S_IDX;
            S_IDX:       n_state = (r_r == '0) ? S_W_MUL : S_UDIV_GO;
            S_UDIV_GO:   n_state = S_UDIV_WAIT;
            S_UDIV_WAIT: if (div_rsp.done) n_state = S_DOT_MUL;
            S_DOT_MUL:   n_state = S_DOT_ADD;
            S_DOT_ADD:   n_state = (r_axis == 2'd2) ? S_W_MUL : S_UDIV_GO;
            S_W_MUL:     n_state = S_UPD;
            S_UPD:       n_state = S_IDLE;
            S_RD_ADDR:   n_state = S_MV_CHK;
            S_MV_CHK:    n_state = (mv_zero || mv_sat) ? S_DN_MUL1 : S_MV_WAIT;
            S_MV_WAIT:   if (div_rsp.done) n_state = S_DN_MUL1;
            S_DN_MUL1:   n_state = S_DN_MUL2;
            S_DN_MUL2:   n_state = S_DN_CHK;
            S_DN_CHK:    n_state = dn_sat ? S_DONE : S_DN_WAIT;
            S_DN_WAIT:   if (div_rsp.done) n_state = S_DONE;
            S_DONE:      if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // control outputs: multiplier operands, divider request, store access, output load
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_req   = '0;
        mem_re    = 1'b0;
        mem_raddr = r_bin;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_SQ_MUL: begin
                mul_a = r_dmag[r_axis][31:0];
                mul_b = r_dmag[r_axis][31:0];
            end
            S_IDX_MUL: begin
                mul_a = r_r;
                mul_b = r_ibw;
            end
            S_IDX: begin
                mem_re    = 1'b1;
                mem_raddr = ind;
            end
            S_UDIV_GO: begin
                div_req.start   = 1'b1;
                div_req.divisor = {16'b0, r_r};
                div_req.rem     = {16'b0, r_dmag[r_axis][32:1]};
                div_req.bits    = {r_dmag[r_axis][0], 31'b0};
                div_req.steps   = STEP_W'(FRAC_BITS + 1);
            end
            S_DOT_MUL: begin
                mul_a = r_vmag[r_axis];
                mul_b = {15'b0, div_rsp.quot[16:0]};
            end
            S_W_MUL: begin
                mul_a = r_mass;
                mul_b = vr_mag;
            end
            S_UPD:     mem_we = 1'b1;
            S_RD_ADDR: mem_re = 1'b1;
            S_MV_CHK: begin
                if (!mv_zero && !mv_sat) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = ent.mass_sum;
                    div_req.rem     = vs_abs[63:16];
                    div_req.bits    = {vs_abs[15:0], 16'b0};
                    div_req.steps   = STEP_W'(QUOT_W);
                end
            end
            S_DN_MUL1: begin
                mul_a = {8'b0, ent.mass_sum[47:24]};
                mul_b = r_iusv;
            end
            S_DN_MUL2: begin
                mul_a = {8'b0, ent.mass_sum[23:0]};
                mul_b = r_iusv;
            end
            S_DN_CHK: begin
                if (!dn_sat) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = {34'b0, dn_k};
                    div_req.rem     = {16'b0, dn_sum[63:32]};
                    div_req.bits    = dn_sum[31:0];
                    div_req.steps   = STEP_W'(QUOT_W);
                end
            end
            S_DONE:    out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    for (int k = 0; k < 3; k++) begin
                        r_dmag[k] <= dabs[k];
                        r_dneg[k] <= dsub[k][32];
                        r_vmag[k] <= vabs[k];
                        r_vneg[k] <= vin[k][31];
                    end
                    r_bin  <= i_read_bin;
                    r_sq   <= '0;
                    r_axis <= '0;
                end
            end
            S_SQ_ADD: begin
                r_sq   <= sq_sum[63:0];
                r_axis <= r_axis + 1'b1;
                r_x    <= sq_sum[63:0];
                r_res  <= '0;
                r_bit  <= 64'h4000000000000000;
                r_cnt  <= '0;
            end
            S_SQRT: begin
                r_x   <= n_x;
                r_res <= n_res;
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31)
                    r_r <= n_res[31:0];
            end
            S_IDX: begin
                r_ind  <= ind;
                r_dot  <= '0;
                r_axis <= '0;
            end
            S_DOT_ADD: begin
                // add the term with the sign of v times u
                if (r_vneg[r_axis] ^ r_dneg[r_axis])
                    r_dot <= r_dot - $signed(term);
                else
                    r_dot <= r_dot + $signed(term);
                r_axis <= r_axis + 1'b1;
            end
            S_W_MUL:   r_vr_neg <= r_dot[49];
            S_MV_CHK: begin
                if (mv_zero)
                    r_mean <= '0;
                else if (mv_sat)
                    r_mean <= mean_sat(32'hFFFFFFFF, ent.vel_sum[63]);
            end
            S_MV_WAIT: begin
                if (div_rsp.done)
                    r_mean <= mean_sat(div_rsp.quot, ent.vel_sum[63]);
            end
            S_DN_MUL2: begin
                r_xh     <= r_prod[54:0];
                r_xh_ovf <= |r_prod[63:55];
            end
            S_DN_CHK:  if (dn_sat) r_dens <= '1;
            S_DN_WAIT: if (div_rsp.done) r_dens <= div_rsp.quot;
            default: ;
        endcase
    end

    // shell store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[r_ind] <= n_entry;
        if (mem_re)
            r_mem_q <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_mem_hit <= 1'b0;
        end else begin
            if (mem_we)
                r_valid[r_ind] <= 1'b1;
            if (mem_re)
                r_mem_hit <= r_valid[mem_raddr];
        end
    end

    // output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (out_load)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_bin   <= r_bin;
            r_o_mean  <= r_mean;
            r_o_dens  <= r_dens;
            r_o_mass  <= ent.mass_sum;
            r_o_count <= ent.count;
        end
    end

    rspb_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid            = r_out_valid;
    assign o_bin_number           = r_o_bin;
    assign o_mean_radial_velocity = r_o_mean;
    assign o_shell_density        = r_o_dens;
    assign o_shell_mass           = r_o_mass;
    assign o_shell_count          = r_o_count;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("item accepted but sequencer stayed idle");
    a_index_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ({1'b0, r_ind} < nb))
        else $error("shell index beyond shells in use");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before transfer");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_state == S_UDIV_WAIT || r_state == S_MV_WAIT
                           || r_state == S_DN_WAIT))
        else $error("divider started outside a wait sequence");

endmodule
